// File: design/tlcsc_pkg.sv
// Shared types, constants and LFSR step functions of the three-LFSR combiner cipher.
// Depends on nothing; every other design file imports it.
package tlcsc_pkg;

   localparam int NUM_LFSR    = 3;
   localparam int LEN_W       = 5;
   localparam int LFSR_W      = 31;
   localparam int TAP_W       = 32;
   localparam int DATA_W      = 8;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int LEN_CFG_W   = NUM_LFSR * LEN_W;
   localparam int KS_STEPS    = DATA_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_RELOAD = 2'd0,
      OP_BIT    = 2'd1,
      OP_BYTE   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_RELOAD,
      CMD_BIT,
      CMD_BYTE
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTHS = 3'd0,
      CSR_TAPS0   = 3'd1,
      CSR_TAPS1   = 3'd2,
      CSR_TAPS2   = 3'd3,
      CSR_SEED0   = 3'd4,
      CSR_SEED1   = 3'd5,
      CSR_SEED2   = 3'd6
   } csr_index_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [DATA_W-1:0] data;
   } job_type;

   typedef struct packed {
      logic [NUM_LFSR-1:0][LEN_W-1:0] len;
      logic [NUM_LFSR-1:0][TAP_W-1:0] taps;
      logic [NUM_LFSR-1:0][TAP_W-1:0] seed;
   } cfg_type;

   typedef struct packed {
      logic [LFSR_W-1:0] state;
      logic              bit_out;
   } step_type;

   function automatic logic [LFSR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [TAP_W-1:0] full;
      full = (TAP_W'(1) << len) - TAP_W'(1);
      return full[LFSR_W-1:0];
   endfunction

   // One right shift with the parity of the tapped bits entering at bit len-1.
   function automatic step_type lfsr_step(input logic [LFSR_W-1:0] st,
                                          input logic [TAP_W-1:0]  taps,
                                          input logic [LEN_W-1:0]  len);
      logic [LFSR_W-1:0] m;
      logic [LFSR_W-1:0] s;
      logic [LFSR_W-1:0] ns;
      logic              fb;
      step_type          r;
      m  = len_mask(len);
      s  = st & m;
      fb = ^(s & taps[LFSR_W-1:0]);
      ns = s >> 1;
      if (len != '0) begin
         ns = ns | (LFSR_W'(fb) << (len - LEN_W'(1)));
      end
      r.state   = ns & m;
      r.bit_out = s[0];
      return r;
   endfunction

   function automatic logic combine(input logic x0, input logic x1, input logic x2);
      return (x0 & x1) ^ (x0 & x2) ^ x2;
   endfunction

endpackage

// File: design/tlcsc_if.sv
// Channel interfaces of the three-LFSR combiner cipher: request, response and CSR write.
// Depends on tlcsc_pkg for field widths.
interface tlcsc_req_if import tlcsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [DATA_W-1:0] data_in;

   modport source (output valid, output opcode, output data_in, input ready);
   modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface tlcsc_rsp_if import tlcsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

interface tlcsc_csr_if import tlcsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: design/tlcsc_csr.sv
// Configuration register file: lengths, tap masks and seeds of the three LFSRs.
// Depends on tlcsc_pkg and tlcsc_csr_if.
module tlcsc_csr import tlcsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tlcsc_csr_if.sink    csr_ch,
   output cfg_type      cfg
);

   logic [LEN_CFG_W-1:0]           lengths_ff, lengths_in;
   logic [NUM_LFSR-1:0][TAP_W-1:0] taps_ff, taps_in;
   logic [NUM_LFSR-1:0][TAP_W-1:0] seed_ff, seed_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      lengths_in = lengths_ff;
      taps_in    = taps_ff;
      seed_in    = seed_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LENGTHS: lengths_in = csr_ch.wdata[LEN_CFG_W-1:0];
            CSR_TAPS0:   taps_in[0] = csr_ch.wdata;
            CSR_TAPS1:   taps_in[1] = csr_ch.wdata;
            CSR_TAPS2:   taps_in[2] = csr_ch.wdata;
            CSR_SEED0:   seed_in[0] = csr_ch.wdata;
            CSR_SEED1:   seed_in[1] = csr_ch.wdata;
            CSR_SEED2:   seed_in[2] = csr_ch.wdata;
            default:     lengths_in = lengths_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lengths_ff <= '0;
         taps_ff    <= '0;
         seed_ff    <= '0;
      end else begin
         lengths_ff <= lengths_in;
         taps_ff    <= taps_in;
         seed_ff    <= seed_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_LFSR; i++) begin
         cfg.len[i] = lengths_ff[i*LEN_W +: LEN_W];
      end
      cfg.taps = taps_ff;
      cfg.seed = seed_ff;
   end

endmodule

// File: design/tlcsc_front.sv
// Front end: accepts request beats, decodes the opcode into a job and queues it.
// Depends on tlcsc_pkg and tlcsc_req_if.
module tlcsc_front import tlcsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tlcsc_req_if.sink  req_ch,
   output logic       job_valid,
   output job_type    job,
   input  logic       job_pop
);

   job_type           queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   job_type           decoded;

   always_comb begin
      decoded.data = req_ch.data_in;
      unique case (req_ch.opcode)
         OP_RELOAD: decoded.cmd = CMD_RELOAD;
         OP_BIT:    decoded.cmd = CMD_BIT;
         OP_BYTE:   decoded.cmd = CMD_BYTE;
         default:   decoded.cmd = CMD_NOP;
      endcase
   end

   assign req_ch.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign job_valid    = (count_ff != '0);
   assign job          = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (job_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !job_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && job_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: design/tlcsc_back.sv
// Back end: holds the three LFSRs, runs one job per cycle unless the response stalls, and registers the response beat.
// Depends on tlcsc_pkg and tlcsc_rsp_if.
module tlcsc_back import tlcsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   tlcsc_rsp_if.source rsp_ch
);

   logic [LFSR_W-1:0] lfsr_ff [NUM_LFSR];
   logic [LFSR_W-1:0] lfsr_in [NUM_LFSR];
   logic [LFSR_W-1:0] work   [NUM_LFSR];
   logic [LFSR_W-1:0] one    [NUM_LFSR];
   logic [LFSR_W-1:0] eight  [NUM_LFSR];
   logic [NUM_LFSR-1:0] xbits;
   logic [DATA_W-1:0] ks;
   logic [DATA_W-1:0] result;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              advance;
   step_type          st;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign job_pop = job_valid && advance;

   // Eight chained steps; the state after the first one serves single-bit jobs.
   always_comb begin
      for (int i = 0; i < NUM_LFSR; i++) begin
         work[i] = lfsr_ff[i];
         one[i]  = lfsr_ff[i];
      end
      ks    = '0;
      xbits = '0;
      st    = '0;
      for (int k = 0; k < KS_STEPS; k++) begin
         for (int i = 0; i < NUM_LFSR; i++) begin
            st       = lfsr_step(work[i], cfg.taps[i], cfg.len[i]);
            work[i]  = st.state;
            xbits[i] = st.bit_out;
         end
         ks[KS_STEPS-1-k] = combine(xbits[0], xbits[1], xbits[2]);
         if (k == 0) begin
            for (int i = 0; i < NUM_LFSR; i++) begin
               one[i] = work[i];
            end
         end
      end
      for (int i = 0; i < NUM_LFSR; i++) begin
         eight[i] = work[i];
      end
   end

   always_comb begin
      result = '0;
      for (int i = 0; i < NUM_LFSR; i++) begin
         lfsr_in[i] = lfsr_ff[i];
      end
      unique case (job.cmd)
         CMD_RELOAD: begin
            for (int i = 0; i < NUM_LFSR; i++) begin
               lfsr_in[i] = cfg.seed[i][LFSR_W-1:0] & len_mask(cfg.len[i]);
            end
         end
         CMD_BIT: begin
            lfsr_in = one;
            result  = DATA_W'(ks[KS_STEPS-1]);
         end
         CMD_BYTE: begin
            lfsr_in = eight;
            result  = job.data ^ ks;
         end
         default: result = '0;
      endcase
   end

   assign rsp_valid_in = advance ? job_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LFSR; i++) begin
            lfsr_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (job_pop) begin
            lfsr_ff <= lfsr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = rsp_data_ff;

endmodule

// File: design/three_lfsr_combiner_stream_cipher.sv
// Top level of the three-LFSR combiner keystream generator and byte cipher.
// Depends on tlcsc_pkg, the tlcsc interfaces, tlcsc_csr, tlcsc_front and tlcsc_back.
//
//   channel  direction  payload                 beat
//   req_ch   in         opcode, data_in         one job
//   rsp_ch   out        data_out                one result per job
//   csr_ch   in         index, wdata            one register write
//
// A job waits in the two-entry queue; its response is registered as the back end pops it.
// The back end retires one job per cycle while the response is not stalled, so one byte
// per cycle is sustained; the eight chained LFSR steps of a byte job set the critical path.
// Synchronous reset clears the LFSRs, the registers, the queue and the response valid.
// A stalled response holds the back end; the queue keeps accepting until it is full.
module three_lfsr_combiner_stream_cipher import tlcsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tlcsc_req_if.sink    req_ch,
   tlcsc_rsp_if.source  rsp_ch,
   tlcsc_csr_if.sink    csr_ch
);

   cfg_type cfg;
   logic    job_valid;
   job_type job;
   logic    job_pop;

   tlcsc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   tlcsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   tlcsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTHESIS
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("job popped from an empty queue");

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> rsp_ch.valid)
      else $error("executed job produced no response beat");

   a_push_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> job_valid)
      else $error("accepted request beat missing from the queue");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid survived reset");
`endif

endmodule

// File: tb/tb_three_lfsr_combiner_stream_cipher.sv
// Self-checking testbench for the three-LFSR combiner keystream cipher.
// It needs tlcsc_pkg, the tlcsc channel interfaces and the top level; a directed plan is
// followed by randomized key settings and jobs, checked against a local predictor or fixed plan values.
`timescale 1ns / 1ps

module tb_three_lfsr_combiner_stream_cipher;
   import tlcsc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int PLAN_LEN     = 36;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 300;
   localparam int HOLD_CYCLES  = 80;
   localparam int TAIL_CYCLES  = 20;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 200;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         reg_idx;
      logic [CSR_DATA_W-1:0] value;
      logic [OP_W-1:0]       op;
      logic [DATA_W-1:0]     din;
      bit                    typed;
      logic [DATA_W-1:0]     want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   tlcsc_req_if req_ch ();
   tlcsc_rsp_if rsp_ch ();
   tlcsc_csr_if csr_ch ();

   three_lfsr_combiner_stream_cipher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [LEN_CFG_W-1:0] key_lengths = '0;
   logic [TAP_W-1:0]     key_taps [NUM_LFSR] = '{default: '0};
   logic [TAP_W-1:0]     key_seed [NUM_LFSR] = '{default: '0};
   logic [LFSR_W-1:0]    key_reg  [NUM_LFSR] = '{default: '0};

   logic [DATA_W-1:0] expected_bytes [$];

   int  fail_count = 0;
   int  results_seen = 0;
   int  csr_writes = 0;
   int  key_settings = 0;
   int  op_count [4] = '{default: 0};
   int  quiet_cycles = 0;
   bit  steady = 1'b0;
   bit  hold_pending = 1'b0;
   bit  csr_open = 1'b0;

   plan_row_type plan [PLAN_LEN] = '{
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_RELOAD, 8'hFF, 1'b1, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BIT,    8'h00, 1'b1, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'h00, 1'b1, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'hFF, 1'b1, 8'hFF},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_UNUSED, 8'hA5, 1'b1, 8'h00},
      '{ROW_CSR,  CSR_LENGTHS, 32'h0000_7FFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_TAPS0,   32'hFFFF_FFFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_TAPS1,   32'hFFFF_FFFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_TAPS2,   32'hFFFF_FFFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_SEED0,   32'hFFFF_FFFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_SEED1,   32'hFFFF_FFFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_SEED2,   32'hFFFF_FFFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_RELOAD, 8'h00, 1'b1, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BIT,    8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'hFF, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_UNUSED, 8'hFF, 1'b1, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BIT,    8'hFF, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_LENGTHS, 32'h0000_0000, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'h81, 1'b1, 8'h81},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BIT,    8'h7E, 1'b1, 8'h00},
      '{ROW_CSR,  CSR_LENGTHS, 32'h0000_7DA8, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_TAPS0,   32'hFFFF_0000, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_SEED0,   32'hFFFF_FF5A, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_RELOAD, 8'h00, 1'b1, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'h3C, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'hC3, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_LENGTHS, 32'h0000_0C41, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'h55, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BIT,    8'h00, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_LENGTHS, 32'hFFFF_FFFF, OP_RELOAD, 8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_RELOAD, 8'h00, 1'b1, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'hAA, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BIT,    8'h00, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'h01, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_LENGTHS, 32'h0,         OP_BYTE,   8'h80, 1'b0, 8'h00}
   };

   function automatic logic [LFSR_W-1:0] length_mask(input logic [LEN_W-1:0] n);
      int unsigned drop;
      drop = 32 - n;
      return LFSR_W'(32'hFFFF_FFFF >> drop);
   endfunction

   function automatic logic next_keystream_bit();
      logic [LEN_W-1:0]    n;
      logic [LFSR_W-1:0]   m;
      logic [LFSR_W-1:0]   s;
      logic [LFSR_W-1:0]   ns;
      logic [NUM_LFSR-1:0] x;
      for (int k = 0; k < NUM_LFSR; k++) begin
         n = key_lengths[LEN_W*k +: LEN_W];
         m = length_mask(n);
         s = key_reg[k] & m;
         x[k] = s[0];
         ns = s >> 1;
         if (n != '0) begin
            ns[n - 1] = ^(s & key_taps[k][LFSR_W-1:0]);
         end
         key_reg[k] = ns & m;
      end
      return (x[0] & x[1]) ^ (x[0] & x[2]) ^ x[2];
   endfunction

   function automatic logic [DATA_W-1:0] cipher_predict(input logic [OP_W-1:0] op,
                                                       input logic [DATA_W-1:0] din);
      logic [DATA_W-1:0] ks;
      ks = '0;
      case (op)
         OP_RELOAD: begin
            for (int k = 0; k < NUM_LFSR; k++) begin
               key_reg[k] = key_seed[k][LFSR_W-1:0] & length_mask(key_lengths[LEN_W*k +: LEN_W]);
            end
            return '0;
         end
         OP_BIT: begin
            return DATA_W'(next_keystream_bit());
         end
         OP_BYTE: begin
            for (int i = 0; i < KS_STEPS; i++) begin
               ks = {ks[DATA_W-2:0], next_keystream_bit()};
            end
            return din ^ ks;
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end else if (r == 2) begin
         return LEN_W'(1);
      end
      return LEN_W'($urandom_range(31));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_word();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end
      return $urandom;
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din,
                            input bit typed, input logic [DATA_W-1:0] want);
      logic [DATA_W-1:0] predicted;
      while (!steady && $urandom_range(99) < 34) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.opcode  <= op;
      req_ch.data_in <= din;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      predicted = cipher_predict(op, din);
      expected_bytes.push_back(typed ? want : predicted);
      op_count[op]++;
   endtask

   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= v;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      case (idx)
         CSR_LENGTHS: key_lengths = v[LEN_CFG_W-1:0];
         CSR_TAPS0:   key_taps[0] = v;
         CSR_TAPS1:   key_taps[1] = v;
         CSR_TAPS2:   key_taps[2] = v;
         CSR_SEED0:   key_seed[0] = v;
         CSR_SEED1:   key_seed[1] = v;
         CSR_SEED2:   key_seed[2] = v;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic program_key(input logic [CSR_DATA_W-1:0] lengths_word);
      settle_block();
      write_reg(CSR_LENGTHS, lengths_word);
      write_reg(CSR_TAPS0, pick_word());
      write_reg(CSR_TAPS1, pick_word());
      write_reg(CSR_TAPS2, pick_word());
      write_reg(CSR_SEED0, pick_word());
      write_reg(CSR_SEED1, pick_word());
      write_reg(CSR_SEED2, pick_word());
      csr_ch.valid <= 1'b0;
      key_settings++;
   endtask

   task automatic check_result(input logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      results_seen++;
      if (expected_bytes.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected result, expected none, got data_out %02h", $time, got);
         end
      end else begin
         want = expected_bytes.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("%0t: data_out mismatch, expected %02h, got %02h", $time, want, got);
            end
         end
      end
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_result(rsp_ch.data_out);
         end
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 34);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("%0t: no beat on any channel for %0d cycles", $time, QUIET_LIMIT);
         $display("three_lfsr_combiner_stream_cipher regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] upper;
      logic [CSR_DATA_W-1:0] lengths_word;
      int unsigned           r;
      logic [OP_W-1:0]       op;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = '0;
      req_ch.data_in = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_LENGTHS;
      csr_ch.wdata   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < PLAN_LEN; row++) begin
         if (plan[row].kind == ROW_CSR) begin
            settle_block();
            write_reg(plan[row].reg_idx, plan[row].value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_ch.valid <= 1'b0;
               csr_open = 1'b0;
            end
            send_item(plan[row].op, plan[row].din, plan[row].typed, plan[row].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         upper = $urandom;
         if (p == 0) begin
            lengths_word = 32'h0000_7FFF;
         end else if (p == 1) begin
            lengths_word = upper & 32'hFFFF_8000;
         end else begin
            lengths_word = {upper[CSR_DATA_W-1:LEN_CFG_W], pick_length(), pick_length(),
                            pick_length()};
         end
         program_key(lengths_word);
         steady = (p == 3);
         // One phase keeps the old register contents so that a length change acts on them.
         if (p != 4) begin
            send_item(OP_RELOAD, DATA_W'($urandom), 1'b0, '0);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == 100) begin
               hold_pending = 1'b1;
            end
            if (p == 4 && i == 150) begin
               settle_block();
            end
            r = $urandom_range(99);
            if (r < 8) begin
               op = OP_RELOAD;
            end else if (r < 40) begin
               op = OP_BIT;
            end else if (r < 96) begin
               op = OP_BYTE;
            end else begin
               op = OP_UNUSED;
            end
            send_item(op, DATA_W'($urandom), 1'b0, '0);
         end
      end

      steady = 1'b0;
      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         fail_count++;
         $display("%0t: %0d results missing, expected %02h first, got none", $time,
                  expected_bytes.size(), expected_bytes[0]);
      end

      $display("Sent %0d jobs: %0d reload, %0d bit, %0d byte, %0d unused opcode.",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("Checked %0d results over %0d register writes and %0d random key settings.",
               results_seen, csr_writes, key_settings);
      if (fail_count == 0) begin
         $display("three_lfsr_combiner_stream_cipher regression: pass");
      end else begin
         $display("three_lfsr_combiner_stream_cipher regression: fail");
      end
      $finish;
   end

endmodule
